/* hw/rtl/ftda_pkg.sv */
// ----------------------------------------------------------------------------
// ftda_pkg: shared constants and types for the fixed-point to text converter
// Number format, ASCII codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package ftda_pkg;

  // number format: INT_BITS integer bits including sign, FRAC_BITS fraction bits
  localparam int INT_BITS   = 16;
  localparam int FRAC_BITS  = 16;
  localparam int TOTAL_BITS = INT_BITS + FRAC_BITS;

  // decimal digits needed for a magnitude up to 2^(INT_BITS-1)
  localparam int INT_DIGITS = (INT_BITS * 30103) / 100000 + 1;
  localparam int BCD_W      = INT_DIGITS * 4;

  // counter for conversion bits and integer digit index
  localparam int CNT_W = $clog2(INT_BITS + 1);

  localparam int FD_W   = 4;
  localparam int CHAR_W = 7;

  localparam logic [FD_W-1:0]   FRAC_DIGITS_RST = FD_W'(2);

  localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(45);
  localparam logic [CHAR_W-1:0] CH_POINT = CHAR_W'(46);
  localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(48);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_CONV,
    ST_INT,
    ST_POINT,
    ST_FRAC
  } state_e;

endpackage

/* hw/rtl/fixed_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii: signed fixed-point number to decimal ASCII text
// Prints one Q15.16 number as sign, integer digits, point and truncated
// fraction digits, at most one character per cycle on a strobed output.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+--------------------
//  number in | value_i                                  | start_i, busy_o
//  text out  | char_code_o, last_char_o                 | char_valid_o strobe
//  config    | frac_digits_i                            | frac_digits_we_i
//
//  A number is taken when start_i is high and busy_o is low.
//  It prints the minus sign (negative numbers only), runs the bit-serial
//  binary to bcd conversion, walks all INT_DIGITS integer digits (leading
//  zeros are dropped without a strobe), then prints the point and the fraction
//  digits if any fraction digits are configured. busy_o stays high until the
//  last character is registered. The last character shows in the first idle
//  cycle, whose edge may already take the next number.
//  Reset is asynchronous and active low; frac_digits comes up as 2.
//  The receiver cannot stall: each character is shown for exactly one cycle.
//
module fixed_to_decimal_ascii
  import ftda_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // number in
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [TOTAL_BITS-1:0] value_i,
  // configuration
  input  logic                  frac_digits_we_i,
  input  logic [FD_W-1:0]       frac_digits_i,
  // text out
  output logic                  char_valid_o,
  output logic [CHAR_W-1:0]     char_code_o,
  output logic                  last_char_o
);

  state_e                state_q, state_d;
  logic [FD_W-1:0]       frac_digits_q;
  logic [INT_BITS-1:0]   int_q, int_d;      // integer magnitude, shifted out msb first
  logic [BCD_W-1:0]      bcd_q, bcd_d;      // bcd digits, most significant on top
  logic [FRAC_BITS-1:0]  frac_q, frac_d;    // remaining binary fraction
  logic [CNT_W-1:0]      cnt_q, cnt_d;      // conversion bit / integer digit count
  logic [FD_W-1:0]       fcnt_q, fcnt_d;    // fraction digits still to print
  logic                  started_q, started_d;

  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_code_q, out_code_d;
  logic                  out_last_q, out_last_d;

  // magnitude of the incoming number
  logic                  in_neg;
  logic [TOTAL_BITS-1:0] in_mag;

  // double dabble step
  logic [BCD_W-1:0]      bcd_adj;

  // fraction times ten
  logic [FRAC_BITS+3:0]  frac_x10;
  logic [3:0]            top_digit;

  assign in_neg = value_i[TOTAL_BITS-1];
  assign in_mag = in_neg ? (~value_i + TOTAL_BITS'(1)) : value_i;

  always_comb begin
    for (int i = 0; i < INT_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  assign frac_x10  = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};
  assign top_digit = bcd_q[BCD_W-1 -: 4];

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_digits_q <= FRAC_DIGITS_RST;
    end else if (frac_digits_we_i) begin
      frac_digits_q <= frac_digits_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      fcnt_q      <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_code_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fcnt_q      <= fcnt_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
      out_code_q  <= out_code_d;
      out_last_q  <= out_last_d;
    end
  end

  // datapath shift registers
  always_ff @(posedge clk_i) begin
    int_q  <= int_d;
    bcd_q  <= bcd_d;
    frac_q <= frac_d;
  end

  always_comb begin
    state_d     = state_q;
    int_d       = int_q;
    bcd_d       = bcd_q;
    frac_d      = frac_q;
    cnt_d       = cnt_q;
    fcnt_d      = fcnt_q;
    started_d   = started_q;
    out_valid_d = 1'b0;
    out_code_d  = out_code_q;
    out_last_d  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          int_d     = in_mag[TOTAL_BITS-1:FRAC_BITS];
          frac_d    = in_mag[FRAC_BITS-1:0];
          bcd_d     = '0;
          cnt_d     = CNT_W'(INT_BITS - 1);
          started_d = 1'b0;
          state_d   = in_neg ? ST_SIGN : ST_CONV;
        end
      end
      ST_SIGN: begin
        out_valid_d = 1'b1;
        out_code_d  = CH_MINUS;
        state_d     = ST_CONV;
      end
      ST_CONV: begin
        // shift one magnitude bit into the bcd digits
        bcd_d = {bcd_adj[BCD_W-2:0], int_q[INT_BITS-1]};
        int_d = {int_q[INT_BITS-2:0], 1'b0};
        if (cnt_q == '0) begin
          cnt_d   = CNT_W'(INT_DIGITS - 1);
          state_d = ST_INT;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_INT: begin
        // drop leading zeros, but always print the units digit
        if (started_q || top_digit != 4'd0 || cnt_q == '0) begin
          out_valid_d = 1'b1;
          out_code_d  = CH_ZERO + CHAR_W'(top_digit);
          started_d   = 1'b1;
        end
        bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
        if (cnt_q == '0) begin
          if (frac_digits_q == '0) begin
            out_last_d = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_POINT;
          end
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_POINT: begin
        out_valid_d = 1'b1;
        out_code_d  = CH_POINT;
        fcnt_d      = frac_digits_q;
        state_d     = ST_FRAC;
      end
      ST_FRAC: begin
        // next truncated digit is the integer part of fraction times ten
        out_valid_d = 1'b1;
        out_code_d  = CH_ZERO + CHAR_W'(frac_x10[FRAC_BITS+3:FRAC_BITS]);
        frac_d      = frac_x10[FRAC_BITS-1:0];
        fcnt_d      = fcnt_q - FD_W'(1);
        if (fcnt_q == FD_W'(1)) begin
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign char_valid_o = out_valid_q;
  assign char_code_o  = out_code_q;
  assign last_char_o  = out_last_q;

endmodule

/* hw/rtl/ftda_checker.sv */
// ----------------------------------------------------------------------------
// ftda_checker: port-level checks for the fixed-point to text converter
// Watches the top level's ports and flags framing slips of the text stream.
// ----------------------------------------------------------------------------
module ftda_checker
  import ftda_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input logic                  char_valid_o,
  input logic [CHAR_W-1:0]     char_code_o,
  input logic                  last_char_o
);

  // an accepted item makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("item accepted but block not busy");

  // a character other than the last belongs to a running item
  a_mid_char_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o && !last_char_o |-> busy_o)
    else $error("non-final character while idle");

  // the block goes idle exactly with the final character
  a_idle_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> char_valid_o && last_char_o)
    else $error("busy fell without final character");

  // nothing follows the final character in the next cycle
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o && last_char_o |=> !char_valid_o)
    else $error("character right after final character");

  // only sign, point and digits are printed
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_valid_o |-> (char_code_o == CH_MINUS || char_code_o == CH_POINT ||
                      (char_code_o >= CH_ZERO && char_code_o <= CH_ZERO + CHAR_W'(9))))
    else $error("character outside sign, point and digits");

endmodule

bind fixed_to_decimal_ascii ftda_checker u_ftda_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .char_valid_o (char_valid_o),
  .char_code_o  (char_code_o),
  .last_char_o  (last_char_o)
);
